### hdl/utf8_stream_decoder_macros.svh
// Assertion macros shared by the UTF-8 stream decoder modules.
`ifndef UTF8_STREAM_DECODER_MACROS_SVH
`define UTF8_STREAM_DECODER_MACROS_SVH

`ifndef SYNTH
`define U8SD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("u8sd: property violated in the same cycle");
`define U8SD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("u8sd: property violated in the next cycle");
`else
`define U8SD_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define U8SD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### hdl/u8sd_pkg.sv
// Types, constants, microcode table and decode helpers of the UTF-8 stream decoder.
`default_nettype none
package u8sd_pkg;

    localparam int BYTE_W  = 8;
    localparam int CP_W    = 21;
    localparam int CNT_W   = 3;
    localparam int HOLD_D  = 4;
    localparam int UPC_W   = 1;

    localparam logic [CP_W-1:0] REPL_CP = 21'h00FFFD;

    localparam logic [BYTE_W-1:0] CONT_MASK = 8'hC0;
    localparam logic [BYTE_W-1:0] CONT_CODE = 8'h80;

    typedef logic [UPC_W-1:0] upc_t;

    localparam upc_t UPC_WAIT = 1'b0;
    localparam upc_t UPC_EVAL = 1'b1;

    typedef enum logic [0:0] {
        COND_IN_VALID = 1'b0,
        COND_RUN_END  = 1'b1
    } cond_t;

    typedef struct packed {
        logic  ready;
        logic  emit;
        cond_t cond;
        upc_t  jump_true;
        upc_t  jump_false;
    } ucode_t;

    typedef struct packed {
        logic load;
        logic commit;
    } ctrl_t;

    typedef struct packed {
        logic emit_ok;
        logic last;
    } stat_t;

    typedef struct packed {
        logic [CP_W-1:0]  code_point;
        logic             replaced;
        logic [CNT_W-1:0] consumed_bytes;
        logic             last_of_run;
    } res_t;

    function automatic ucode_t ucode_rom(input upc_t upc);
        ucode_t w;
        unique case (upc)
            UPC_WAIT: w = '{ready: 1'b1, emit: 1'b0, cond: COND_IN_VALID,
                            jump_true: UPC_EVAL, jump_false: UPC_WAIT};
            UPC_EVAL: w = '{ready: 1'b0, emit: 1'b1, cond: COND_RUN_END,
                            jump_true: UPC_WAIT, jump_false: UPC_EVAL};
            default:  w = '{ready: 1'b0, emit: 1'b0, cond: COND_RUN_END,
                            jump_true: UPC_WAIT, jump_false: UPC_WAIT};
        endcase
        return w;
    endfunction

    function automatic logic [CNT_W-1:0] seq_len(input logic [BYTE_W-1:0] lead);
        logic [CNT_W-1:0] n;
        if (!lead[7]) begin
            n = 3'd1;
        end else if (lead[7:5] == 3'b110) begin
            n = 3'd2;
        end else if (lead[7:4] == 4'b1110) begin
            n = 3'd3;
        end else if (lead[7:3] == 5'b11110) begin
            n = 3'd4;
        end else begin
            n = 3'd0;
        end
        return n;
    endfunction

endpackage
`default_nettype wire

### hdl/u8sd_datapath.sv
// Byte holding register, sequence decode and lookahead of the UTF-8 stream decoder.
`default_nettype none
`include "utf8_stream_decoder_macros.svh"
module u8sd_datapath import u8sd_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic [BYTE_W-1:0] byte_in,
    input  wire logic              eos_in,
    input  wire ctrl_t             ctrl,
    output stat_t                  stat,
    output res_t                   res
);

    logic [HOLD_D-1:0][BYTE_W-1:0] held_reg, held_next;
    logic [CNT_W-1:0]              count_reg, count_next;
    logic                          eos_reg, eos_next;

    logic [BYTE_W-1:0]             lead;
    logic [CNT_W-1:0]              need;
    logic                          cont_bad;
    logic                          short_seq;
    logic [CNT_W-1:0]              drop;
    logic [CNT_W-1:0]              rem;
    logic [HOLD_D-1:0][BYTE_W-1:0] shifted;
    logic [CNT_W-1:0]              next_need;
    logic [CP_W-1:0]               cp;

    assign lead      = held_reg[0];
    assign need      = seq_len(lead);
    assign short_seq = (need != 3'd0) && (need > count_reg);

    always_comb begin
        cont_bad = 1'b0;
        for (int i = 1; i < HOLD_D; i++) begin
            if ((CNT_W'(i) < need) &&
                ((held_reg[i] & CONT_MASK) != CONT_CODE)) begin
                cont_bad = 1'b1;
            end
        end
    end

    always_comb begin
        case (need)
            3'd2:    cp = {10'd0, lead[4:0], held_reg[1][5:0]};
            3'd3:    cp = {5'd0, lead[3:0], held_reg[1][5:0], held_reg[2][5:0]};
            3'd4:    cp = {lead[2:0], held_reg[1][5:0], held_reg[2][5:0],
                           held_reg[3][5:0]};
            default: cp = {13'd0, lead};
        endcase
    end

    always_comb begin
        res.code_point     = REPL_CP;
        res.replaced       = 1'b1;
        res.consumed_bytes = 3'd1;
        res.last_of_run    = stat.last;
        drop               = 3'd1;
        if (need == 3'd0) begin
            drop = 3'd1;
        end else if (short_seq) begin
            res.consumed_bytes = count_reg;
            drop               = count_reg;
        end else if (cont_bad) begin
            drop = 3'd1;
        end else begin
            res.code_point     = cp;
            res.replaced       = 1'b0;
            res.consumed_bytes = need;
            drop               = need;
        end
    end

    assign rem       = count_reg - drop;
    assign shifted   = held_reg >> {drop, 3'b000};
    assign next_need = seq_len(shifted[0]);

    assign stat.emit_ok   = !(short_seq && !eos_reg);
    assign stat.last      = (rem == 3'd0) ||
                            (!eos_reg && (next_need != 3'd0) && (next_need > rem));

    always_comb begin
        held_next  = held_reg;
        count_next = count_reg;
        eos_next   = eos_reg;
        if (ctrl.load) begin
            held_next[count_reg[1:0]] = byte_in;
            count_next                = count_reg + 3'd1;
            eos_next                  = eos_in;
        end else if (ctrl.commit) begin
            held_next  = shifted;
            count_next = rem;
        end
    end

    always_ff @(posedge aclk) begin
        held_reg <= held_next;
        if (!aresetn) begin
            count_reg <= '0;
            eos_reg   <= 1'b0;
        end else begin
            count_reg <= count_next;
            eos_reg   <= eos_next;
        end
    end

    `U8SD_ASSERT_SAME(a_load_has_room, aclk, aresetn, ctrl.load, count_reg < 3'd4)
    `U8SD_ASSERT_SAME(a_commit_emits, aclk, aresetn, ctrl.commit, stat.emit_ok)
    `U8SD_ASSERT_NEXT(a_eos_empties, aclk, aresetn,
                      ctrl.commit && stat.last && eos_reg, count_reg == 3'd0)

endmodule
`default_nettype wire

### hdl/u8sd_sequencer.sv
// Microcode step counter, control store and branch logic of the UTF-8 stream decoder.
`default_nettype none
`include "utf8_stream_decoder_macros.svh"
module u8sd_sequencer import u8sd_pkg::*; (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  in_valid,
    input  wire logic  out_free,
    input  wire stat_t stat,
    output logic       in_ready,
    output ctrl_t      ctrl
);

    upc_t   upc_reg, upc_next;
    ucode_t word;
    logic   cond_val;
    logic   emit_req;
    logic   stall;

    assign word = ucode_rom(upc_reg);

    always_comb begin
        unique case (word.cond)
            COND_IN_VALID: cond_val = in_valid;
            COND_RUN_END:  cond_val = !stat.emit_ok || stat.last;
            default:       cond_val = 1'b0;
        endcase
    end

    assign emit_req    = word.emit && stat.emit_ok;
    assign stall       = emit_req && !out_free;
    assign in_ready    = word.ready;
    assign ctrl.load   = word.ready && in_valid;
    assign ctrl.commit = emit_req && out_free;

    always_comb begin
        if (stall) begin
            upc_next = upc_reg;
        end else if (cond_val) begin
            upc_next = word.jump_true;
        end else begin
            upc_next = word.jump_false;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= UPC_WAIT;
        end else begin
            upc_reg <= upc_next;
        end
    end

    `U8SD_ASSERT_SAME(a_load_xor_commit, aclk, aresetn, ctrl.load, !ctrl.commit)
    `U8SD_ASSERT_NEXT(a_stall_holds_step, aclk, aresetn, stall, $stable(upc_reg))

endmodule
`default_nettype wire

### hdl/utf8_stream_decoder.sv
// Top level of the UTF-8 stream decoder: sequencer, datapath and result register.
//
//   Channel  Direction  tdata (low bit up)                              tuser  tlast
//   s_       in         byte_in[7:0]                                     -      end_of_stream
//   m_       out        code_point[20:0] replaced consumed_bytes[2:0]    -      last_of_run
//
// A byte is accepted in the wait step, and the held sequence is judged in the evaluate step.
// Every further result caused by the same byte repeats the evaluate step.
// A full result register holds the evaluate step until the beat is taken.
// Reset clears the byte count and the step counter; held bytes are not cleared.
`default_nettype none
module utf8_stream_decoder import u8sd_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // byte_in[7:0]
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // code_point[20:0], replaced, consumed_bytes[2:0]
    output logic             m_tlast
);

    ctrl_t ctrl;
    stat_t stat;
    res_t  res;
    res_t  out_reg;
    logic  out_valid_reg, out_valid_next;
    logic  out_free;

    assign out_free = !out_valid_reg || m_tready;

    u8sd_sequencer u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .out_free (out_free),
        .stat     (stat),
        .in_ready (s_tready),
        .ctrl     (ctrl)
    );

    u8sd_datapath u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .byte_in (s_tdata),
        .eos_in  (s_tlast),
        .ctrl    (ctrl),
        .stat    (stat),
        .res     (res)
    );

    always_comb begin
        out_valid_next = out_valid_reg;
        if (ctrl.commit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.commit) begin
            out_reg <= res;
        end
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_reg.consumed_bytes, out_reg.replaced, out_reg.code_point};
    assign m_tlast  = out_reg.last_of_run;

endmodule
`default_nettype wire

### tb/utf8_stream_decoder_check.sv
// Checker for the UTF-8 stream decoder: predicts code points from byte beats and compares results.
module utf8_stream_decoder_check import u8sd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // byte_in[7:0]
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,   // code_point[20:0], replaced, consumed_bytes[2:0]
    input  logic        m_tlast,
    output int          fail_count,
    output int          pending
);
    localparam logic [7:0] TWO_MASK   = 8'hE0;
    localparam logic [7:0] TWO_CODE   = 8'hC0;
    localparam logic [7:0] THREE_MASK = 8'hF0;
    localparam logic [7:0] THREE_CODE = 8'hE0;
    localparam logic [7:0] FOUR_MASK  = 8'hF8;
    localparam logic [7:0] FOUR_CODE  = 8'hF0;

    res_t       code_points_due[$];
    logic [7:0] seq_bytes [HOLD_D];
    int         seq_count;

    function automatic int lead_len(input logic [7:0] lead);
        if (lead[7] == 1'b0) return 1;
        if ((lead & TWO_MASK) == TWO_CODE) return 2;
        if ((lead & THREE_MASK) == THREE_CODE) return 3;
        if ((lead & FOUR_MASK) == FOUR_CODE) return 4;
        return 0;
    endfunction

    function automatic void drop_front(input int n);
        for (int i = 0; i + n < seq_count; i++) seq_bytes[i] = seq_bytes[i + n];
        seq_count = (n >= seq_count) ? 0 : seq_count - n;
    endfunction

    function automatic void decode_byte(input logic [7:0] b, input logic eos);
        res_t            run [HOLD_D];
        int              n_res;
        int              need;
        bit              ok;
        logic [CP_W-1:0] cp;
        seq_bytes[seq_count] = b;
        seq_count++;
        n_res = 0;
        while (seq_count > 0 && n_res < HOLD_D) begin
            need = lead_len(seq_bytes[0]);
            if (need != 0 && need > seq_count) begin
                // The stream ended inside a sequence: everything held becomes one replacement.
                if (eos) begin
                    run[n_res] = '{REPL_CP, 1'b1, 3'(seq_count), 1'b0};
                    n_res++;
                end
                break;
            end
            ok = (need != 0);
            for (int i = 1; i < need; i++) begin
                if ((seq_bytes[i] & CONT_MASK) != CONT_CODE) ok = 1'b0;
            end
            if (!ok) begin
                run[n_res] = '{REPL_CP, 1'b1, 3'd1, 1'b0};
                n_res++;
                drop_front(1);
            end else begin
                case (need)
                    1: cp = {13'd0, seq_bytes[0]};
                    2: cp = {10'd0, seq_bytes[0][4:0], seq_bytes[1][5:0]};
                    3: cp = {5'd0, seq_bytes[0][3:0], seq_bytes[1][5:0], seq_bytes[2][5:0]};
                    default: cp = {seq_bytes[0][2:0], seq_bytes[1][5:0], seq_bytes[2][5:0],
                                   seq_bytes[3][5:0]};
                endcase
                run[n_res] = '{cp, 1'b0, 3'(need), 1'b0};
                n_res++;
                drop_front(need);
            end
        end
        if (eos) seq_count = 0;
        if (n_res > 0) run[n_res - 1].last_of_run = 1'b1;
        for (int i = 0; i < n_res; i++) code_points_due.push_back(run[i]);
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin
        res_t want;
        if (!aresetn) begin
            seq_count = 0;
            code_points_due.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (code_points_due.size() == 0) begin
                    $error("unexpected result beat: code_point %0h", m_tdata[20:0]);
                    fail_count++;
                end else begin
                    want = code_points_due.pop_front();
                    check_field("code_point", 32'(want.code_point), 32'(m_tdata[20:0]));
                    check_field("replaced", 32'(want.replaced), 32'(m_tdata[21]));
                    check_field("consumed_bytes", 32'(want.consumed_bytes), 32'(m_tdata[24:22]));
                    check_field("last_of_run", 32'(want.last_of_run), 32'(m_tlast));
                    check_field("tdata padding", 32'd0, 32'(m_tdata[31:25]));
                end
            end
            if (s_tvalid && s_tready) decode_byte(s_tdata, s_tlast);
        end
        pending = code_points_due.size();
    end
endmodule

### tb/utf8_stream_decoder_test.sv
// Testbench top for the UTF-8 stream decoder: drives byte beats and result backpressure.
module utf8_stream_decoder_test;
    localparam int QUIET_LIMIT  = 1000;
    localparam int RANDOM_BYTES = 245;
    localparam int END_CYCLES   = 20;

    // Each entry is {end_of_stream, byte_in}.
    localparam logic [8:0] DIRECTED [25] = '{
        9'h000, 9'h07F,
        9'h0C2, 9'h0A9,
        9'h0E2, 9'h082, 9'h0AC,
        9'h0F7, 9'h0BF, 9'h0BF, 9'h0BF,
        9'h080, 9'h0F8, 9'h0FF,
        9'h0E2, 9'h041, 9'h042,
        9'h0F0, 9'h080, 9'h080, 9'h041,
        9'h0F0, 9'h09F, 9'h198,
        9'h1C3
    };

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;   // byte_in[7:0]
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;           // code_point[20:0], replaced, consumed_bytes[2:0]
    logic        m_tlast;
    bit          idle_on = 1'b1;
    bit          paused;
    int          bytes_sent;
    int          quiet_cycles;
    int          pick;
    int          fail_count;
    int          pending;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    utf8_stream_decoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    utf8_stream_decoder_check decode_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always @(posedge aclk) begin
        m_tready <= !idle_on || ($urandom_range(99) >= 34);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[utf8_stream_decoder] ERROR");
            $finish;
        end
    end

    task automatic send_beat(input logic [7:0] b, input logic eos);
        while (idle_on && $urandom_range(99) < 34) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eos;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        bytes_sent++;
    endtask

    task automatic send_char(input int len, input logic eos);
        logic [20:0] v;
        logic [7:0]  lead;
        v = 21'($urandom);
        case (len)
            1: lead = {1'b0, v[6:0]};
            2: lead = {3'b110, v[10:6]};
            3: lead = {4'b1110, v[15:12]};
            default: lead = {5'b11110, v[20:18]};
        endcase
        send_beat(lead, eos && len == 1);
        for (int i = len - 2; i >= 0; i--) send_beat({2'b10, v[6*i +: 6]}, eos && i == 0);
    endtask

    // A lead with too few continuations, cut off either by a non-continuation
    // byte or by the end of the stream.
    task automatic send_broken();
        logic [7:0] seq [5];
        logic [7:0] tail;
        int         len;
        int         n;
        bit         cut;
        len = $urandom_range(4, 2);
        n = $urandom_range(len - 2, 0) + 1;
        seq[0] = 8'($urandom);
        case (len)
            2: seq[0][7:5] = 3'b110;
            3: seq[0][7:4] = 4'b1110;
            default: seq[0][7:3] = 5'b11110;
        endcase
        for (int i = 1; i < n; i++) seq[i] = {2'b10, 6'($urandom)};
        cut = ($urandom_range(3) == 0);
        if (!cut) begin
            tail = 8'($urandom);
            if (tail[7:6] == 2'b10) tail[6] = 1'b1;
            seq[n] = tail;
            n++;
        end
        for (int i = 0; i < n; i++) send_beat(seq[i], cut && i == n - 1);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        wait (pending == 0);
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        foreach (DIRECTED[i]) send_beat(DIRECTED[i][7:0], DIRECTED[i][8]);
        wait_drained();

        bytes_sent = 0;
        idle_on = 1'b0;
        while (bytes_sent < RANDOM_BYTES) begin
            if (bytes_sent >= 60) idle_on = 1'b1;
            if (bytes_sent >= 160 && !paused) begin
                wait_drained();
                paused = 1'b1;
            end
            pick = $urandom_range(99);
            if (pick < 70) begin
                send_char($urandom_range(4, 1), $urandom_range(15) == 0);
            end else if (pick < 82) begin
                send_beat(8'($urandom), $urandom_range(9) == 0);
            end else begin
                send_broken();
            end
        end

        wait_drained();
        repeat (END_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("[utf8_stream_decoder] OK");
        end else begin
            $display("[utf8_stream_decoder] ERROR");
        end
        $finish;
    end
endmodule

### utf8_stream_decoder.f
+incdir+hdl
hdl/u8sd_pkg.sv
hdl/u8sd_datapath.sv
hdl/u8sd_sequencer.sv
hdl/utf8_stream_decoder.sv
tb/utf8_stream_decoder_check.sv
tb/utf8_stream_decoder_test.sv
